/* sv/rls_pkg.sv */
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types and constants of the radial LED shader: sequencer states,
// register map codes, field widths and step counts of the serial units.
// ----------------------------------------------------------------------------
package rls_pkg;

   localparam int PIXEL_COUNT_DEF = 1024;

   localparam int COORD_W = 10;
   localparam int INDEX_W = 10;
   localparam int COLOR_W = 32;
   localparam int LEVEL_W = 8;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int DIST_W  = SQ_W + 1;
   localparam int RAD_W   = DIST_W + (DIST_W % 2);
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int CNT_W   = 4;
   localparam int ADDR_W  = 5;
   localparam int CSR_W   = 32;

   localparam logic [CNT_W-1:0] SQ_STEPS    = CNT_W'(COORD_W);
   localparam logic [CNT_W-1:0] ROOT_STEPS  = CNT_W'(ROOT_W);
   localparam logic [CNT_W-1:0] SCALE_STEPS = CNT_W'(LEVEL_W);

   localparam logic [LEVEL_W-1:0] BRIGHT_MAX = 8'hFA;
   localparam logic [COLOR_W-1:0] DARK_VALUE = 32'h0000_0000;

   localparam logic [2:0] REG_CENTER_X    = 3'd0;
   localparam logic [2:0] REG_CENTER_Y    = 3'd1;
   localparam logic [2:0] REG_SHADE_COLOR = 3'd2;
   localparam logic [2:0] REG_INTENSITY   = 3'd3;
   localparam logic [2:0] REG_OR_MODE     = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_RESOLVE,
      ST_SCALE
   } state_type;

endpackage

/* sv/radial_led_shader.sv */
// ----------------------------------------------------------------------------
// radial_led_shader
// Shades one LED pixel per request by its distance from a programmed center:
// bit-serial squares, a two-bit-per-step ceiling square root, and a
// bit-serial brightness times color product.
//
// Sequence: an accepted request runs 10 square steps, 11 root steps, a resolve
// state and 8 scale steps; the last scale step loads the result registers and
// raises the result strobe. Busy stays high until then, so requests are taken
// one at a time; busy drops while the strobe shows, so the next request is
// taken in the strobe cycle.
// Reset: synchronous; clears the sequencer, the strobe and all CSRs to 0.
// ----------------------------------------------------------------------------
module radial_led_shader #(
   parameter int PIXEL_COUNT = rls_pkg::PIXEL_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rls_pkg::INDEX_W-1:0]   req_pixel_index,
   input  logic [rls_pkg::COORD_W-1:0]   req_pixel_x,
   input  logic [rls_pkg::COORD_W-1:0]   req_pixel_y,
   input  logic [rls_pkg::COLOR_W-1:0]   req_old_value,
   output logic                          rsp_strobe,
   output logic [rls_pkg::INDEX_W-1:0]   rsp_out_index,
   output logic [rls_pkg::COLOR_W-1:0]   rsp_new_value,
   output logic                          rsp_write_pixel,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rls_pkg::ADDR_W-1:0]    paddr,
   input  logic [rls_pkg::CSR_W-1:0]     pwdata,
   output logic [rls_pkg::CSR_W-1:0]     prdata,
   output logic                          pready
);
   import rls_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [COORD_W-1:0]   center_x_ff, center_y_ff;
   logic [COLOR_W-1:0]   shade_color_ff;
   logic [LEVEL_W-1:0]   intensity_ff;
   logic                 or_mode_ff;

   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [COLOR_W-1:0]   old_ff, old_in;
   logic                 in_range_ff, in_range_in;
   logic                 lit_ff, lit_in;

   logic [SQ_W-1:0]      mcand_x_ff, mcand_x_in, mcand_y_ff, mcand_y_in;
   logic [COORD_W-1:0]   mplr_x_ff, mplr_x_in, mplr_y_ff, mplr_y_in;
   logic [SQ_W-1:0]      acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;

   logic [RAD_W-1:0]     rad_ff, rad_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;

   logic [COLOR_W-1:0]   mcand_c_ff, mcand_c_in, prod_ff, prod_in;
   logic [LEVEL_W-1:0]   mplr_c_ff, mplr_c_in;

   logic                 strobe_ff, strobe_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [COLOR_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_write_ff, rsp_write_in;

   logic [COORD_W-1:0]   dx, dy;
   logic [REM_W+1:0]     rem_try, trial;
   logic [ROOT_W:0]      r_ceil;
   logic [LEVEL_W-1:0]   bright;
   logic                 lit_now;
   logic                 csr_write;

   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         shade_color_ff <= '0;
         intensity_ff   <= '0;
         or_mode_ff     <= 1'b0;
      end else if (csr_write) begin
         case (paddr[4:2])
            REG_CENTER_X:    center_x_ff    <= pwdata[COORD_W-1:0];
            REG_CENTER_Y:    center_y_ff    <= pwdata[COORD_W-1:0];
            REG_SHADE_COLOR: shade_color_ff <= pwdata[COLOR_W-1:0];
            REG_INTENSITY:   intensity_ff   <= pwdata[LEVEL_W-1:0];
            REG_OR_MODE:     or_mode_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_CENTER_X:    prdata = CSR_W'(center_x_ff);
         REG_CENTER_Y:    prdata = CSR_W'(center_y_ff);
         REG_SHADE_COLOR: prdata = CSR_W'(shade_color_ff);
         REG_INTENSITY:   prdata = CSR_W'(intensity_ff);
         REG_OR_MODE:     prdata = CSR_W'(or_mode_ff);
         default:         prdata = '0;
      endcase
   end

   // drop an axis whose center is zero
   assign dx = (center_x_ff == '0) ? '0 :
               (req_pixel_x >= center_x_ff) ? (req_pixel_x - center_x_ff)
                                            : (center_x_ff - req_pixel_x);
   assign dy = (center_y_ff == '0) ? '0 :
               (req_pixel_y >= center_y_ff) ? (req_pixel_y - center_y_ff)
                                            : (center_y_ff - req_pixel_y);

   assign rem_try = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};

   always_comb begin
      r_ceil = {1'b0, root_ff} + (ROOT_W + 1)'(rem_ff != '0);
      if (r_ceil == '0) begin
         r_ceil = (ROOT_W + 1)'(1);
      end
      lit_now = (r_ceil < (ROOT_W + 1)'(intensity_ff));
      bright  = intensity_ff - r_ceil[LEVEL_W-1:0];
      if (bright > BRIGHT_MAX) begin
         bright = BRIGHT_MAX;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      old_in       = old_ff;
      in_range_in  = in_range_ff;
      lit_in       = lit_ff;
      mcand_x_in   = mcand_x_ff;
      mcand_y_in   = mcand_y_ff;
      mplr_x_in    = mplr_x_ff;
      mplr_y_in    = mplr_y_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      mcand_c_in   = mcand_c_ff;
      mplr_c_in    = mplr_c_ff;
      prod_in      = prod_ff;
      strobe_in    = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_write_in = rsp_write_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in      = req_pixel_index;
               old_in      = req_old_value;
               in_range_in = (32'(req_pixel_index) < 32'(PIXEL_COUNT));
               mcand_x_in  = SQ_W'(dx);
               mcand_y_in  = SQ_W'(dy);
               mplr_x_in   = dx;
               mplr_y_in   = dy;
               acc_x_in    = '0;
               acc_y_in    = '0;
               cnt_in      = '0;
               state_in    = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mplr_x_ff[0]) begin
               acc_x_in = acc_x_ff + mcand_x_ff;
            end
            if (mplr_y_ff[0]) begin
               acc_y_in = acc_y_ff + mcand_y_ff;
            end
            mcand_x_in = mcand_x_ff << 1;
            mcand_y_in = mcand_y_ff << 1;
            mplr_x_in  = mplr_x_ff >> 1;
            mplr_y_in  = mplr_y_ff >> 1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == SQ_STEPS - 1'b1) begin
               rad_in   = RAD_W'(DIST_W'(acc_x_in) + DIST_W'(acc_y_in));
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rem_try >= trial) begin
               rem_in  = REM_W'(rem_try - trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = REM_W'(rem_try);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            rad_in = rad_ff << 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ROOT_STEPS - 1'b1) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            lit_in     = lit_now;
            mcand_c_in = shade_color_ff;
            mplr_c_in  = lit_now ? bright : '0;
            prod_in    = '0;
            cnt_in     = '0;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            if (mplr_c_ff[0]) begin
               prod_in = prod_ff + mcand_c_ff;
            end
            mcand_c_in = mcand_c_ff << 1;
            mplr_c_in  = mplr_c_ff >> 1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == SCALE_STEPS - 1'b1) begin
               rsp_index_in = idx_ff;
               rsp_value_in = old_ff;
               rsp_write_in = 1'b0;
               if (in_range_ff) begin
                  if (lit_ff) begin
                     rsp_value_in = or_mode_ff ? (old_ff | prod_in) : prod_in;
                     rsp_write_in = 1'b1;
                  end else if (!or_mode_ff) begin
                     rsp_value_in = DARK_VALUE;
                     rsp_write_in = 1'b1;
                  end
               end
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      old_ff       <= old_in;
      in_range_ff  <= in_range_in;
      lit_ff       <= lit_in;
      mcand_x_ff   <= mcand_x_in;
      mcand_y_ff   <= mcand_y_in;
      mplr_x_ff    <= mplr_x_in;
      mplr_y_ff    <= mplr_y_in;
      acc_x_ff     <= acc_x_in;
      acc_y_ff     <= acc_y_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      mcand_c_ff   <= mcand_c_in;
      mplr_c_ff    <= mplr_c_in;
      prod_ff      <= prod_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_write_ff <= rsp_write_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_out_index   = rsp_index_ff;
   assign rsp_new_value   = rsp_value_ff;
   assign rsp_write_pixel = rsp_write_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while sequencer busy");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && state_ff == ST_SQUARE))
      else $error("accepted request did not start the square phase");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (rem_ff <= {root_ff, 1'b0}))
      else $error("root remainder exceeds twice the partial root");

endmodule

/* dv/radial_led_shader_test.sv */
// ----------------------------------------------------------------------------
// radial_led_shader_test
// Self-checking testbench for the radial LED shader. A scoreboard class keeps
// its own copy of the CSRs and works out the shaded pixel for every accepted
// request; each result strobe is compared field by field with the oldest
// pending pixel. A few directed requests cover the extremes of the fields,
// zero distance, dark pixels in both modes, ignored axes and writes to
// unmapped CSRs. Random phases follow, each with its own CSR setting; most
// have random start gaps, and most pixels lie near the programmed center.
// ----------------------------------------------------------------------------
module radial_led_shader_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rls_pkg::*;

   localparam int PIXELS          = PIXEL_COUNT_DEF;
   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int MAX_REPORTS     = 10;

   localparam logic [2:0] REG_UNUSED_LO = 3'd5;
   localparam logic [2:0] REG_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [COLOR_W-1:0] value;
      logic               write;
   } shaded_pixel_type;

   class shade_scoreboard;
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [COLOR_W-1:0] shade_color;
      logic [LEVEL_W-1:0] intensity;
      logic               or_mode;
      shaded_pixel_type   pending_q[$];
      int                 mismatches;

      function new();
         center_x    = '0;
         center_y    = '0;
         shade_color = '0;
         intensity   = '0;
         or_mode     = 1'b0;
         mismatches  = 0;
      endfunction

      function void set_register(logic [2:0] code, logic [CSR_W-1:0] data);
         case (code)
            REG_CENTER_X:    center_x    = data[COORD_W-1:0];
            REG_CENTER_Y:    center_y    = data[COORD_W-1:0];
            REG_SHADE_COLOR: shade_color = data[COLOR_W-1:0];
            REG_INTENSITY:   intensity   = data[LEVEL_W-1:0];
            REG_OR_MODE:     or_mode     = data[0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [INDEX_W-1:0] index, logic [COORD_W-1:0] x,
                                 logic [COORD_W-1:0] y, logic [COLOR_W-1:0] old);
         int unsigned   dist2;
         int unsigned   d;
         int unsigned   root;
         int unsigned   level;
         logic [COLOR_W-1:0] product;
         shaded_pixel_type shade;
         dist2 = 0;
         if (center_x != 0) begin
            d = (x >= center_x) ? x - center_x : center_x - x;
            dist2 += d * d;
         end
         if (center_y != 0) begin
            d = (y >= center_y) ? y - center_y : center_y - y;
            dist2 += d * d;
         end
         root = 0;
         while (root * root < dist2)
            root++;
         if (root < 1)
            root = 1;
         shade.index = index;
         shade.value = old;
         shade.write = 1'b0;
         if (index < PIXELS) begin
            if (intensity > root) begin
               level = intensity - root;
               if (level > BRIGHT_MAX)
                  level = BRIGHT_MAX;
               product = shade_color * COLOR_W'(level);
               shade.value = or_mode ? (old | product) : product;
               shade.write = 1'b1;
            end else if (!or_mode) begin
               shade.value = DARK_VALUE;
               shade.write = 1'b1;
            end
         end
         pending_q.push_back(shade);
      endfunction

      function void check_result(logic [INDEX_W-1:0] index, logic [COLOR_W-1:0] value,
                                 logic write);
         shaded_pixel_type want;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result with no request pending: index %0d new_value %h write %b",
                        index, value, write);
            return;
         end
         want = pending_q.pop_front();
         if (want.index !== index || want.value !== value || want.write !== write) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch: index exp %0d act %0d, new_value exp %h act %h, %s",
                        want.index, index, want.value, value,
                        $sformatf("write_pixel exp %b act %b", want.write, write));
         end
      endfunction

      function int pending();
         return pending_q.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 start           = 1'b0;
   logic                 busy;
   logic [INDEX_W-1:0]   req_pixel_index = '0;
   logic [COORD_W-1:0]   req_pixel_x     = '0;
   logic [COORD_W-1:0]   req_pixel_y     = '0;
   logic [COLOR_W-1:0]   req_old_value   = '0;
   logic                 rsp_strobe;
   logic [INDEX_W-1:0]   rsp_out_index;
   logic [COLOR_W-1:0]   rsp_new_value;
   logic                 rsp_write_pixel;
   logic                 psel            = 1'b0;
   logic                 penable         = 1'b0;
   logic                 pwrite          = 1'b0;
   logic [ADDR_W-1:0]    paddr           = '0;
   logic [CSR_W-1:0]     pwdata          = '0;
   logic [CSR_W-1:0]     prdata;
   logic                 pready;

   int                   idle_cycles     = 0;
   shade_scoreboard      sb              = new();

   radial_led_shader #(
      .PIXEL_COUNT(PIXELS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pixel_index(req_pixel_index),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .req_old_value(req_old_value),
      .rsp_strobe(rsp_strobe),
      .rsp_out_index(rsp_out_index),
      .rsp_new_value(rsp_new_value),
      .rsp_write_pixel(rsp_write_pixel),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1)
         sb.check_result(rsp_out_index, rsp_new_value, rsp_write_pixel);
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_strobe === 1'b1 || (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("radial_led_shader_test NOT OK");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [2:0] code, logic [CSR_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {code, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.set_register(code, data);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [INDEX_W-1:0] index, logic [COORD_W-1:0] x,
                             logic [COORD_W-1:0] y, logic [COLOR_W-1:0] old);
      req_pixel_index <= index;
      req_pixel_x     <= x;
      req_pixel_y     <= y;
      req_old_value   <= old;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(index, x, y, old);
   endtask

   task automatic drain();
      while (sb.pending() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   // fill the bits above the register width with noise
   function automatic logic [CSR_W-1:0] padded(logic [CSR_W-1:0] value, int width);
      logic [CSR_W-1:0] mask;
      mask = (width >= CSR_W) ? '1 : ((CSR_W'(1) << width) - 1);
      return ($urandom & ~mask) | (value & mask);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic logic [COORD_W-1:0] pick_center();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      else if (r == 1)
         return '1;
      else
         return COORD_W'($urandom_range(1, 1022));
   endfunction

   function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 400)) - 200;
      if (v < 0)
         v = 0;
      if (v > 1023)
         v = 1023;
      return COORD_W'(v);
   endfunction

   function automatic logic [COLOR_W-1:0] pick_old();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      else if (r == 1)
         return '1;
      else
         return $urandom;
   endfunction

   initial begin : stimulus
      int                 gap;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [COLOR_W-1:0] color;
      logic [LEVEL_W-1:0] level;
      logic               mode;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: everything dark, written as zero
      send_pixel(10'd0, 10'd0, 10'd0, 32'h0000_0000);
      start <= 1'b0;
      drain();

      // x axis only, full intensity, write mode
      csr_write(REG_CENTER_X, 32'hFFFF_FE00);
      csr_write(REG_CENTER_Y, 32'hFFFF_FC00);
      csr_write(REG_SHADE_COLOR, 32'h0101_0101);
      csr_write(REG_INTENSITY, 32'hFFFF_FFFF);
      csr_write(REG_OR_MODE, 32'hFFFF_FFFE);
      send_pixel(10'd1023, 10'd512, 10'd1023, 32'hFFFF_FFFF);
      send_pixel(10'd0, 10'd0, 10'd0, 32'h0000_0000);
      send_pixel(10'd512, 10'd760, 10'd0, 32'hA5A5_A5A5);
      send_pixel(10'd3, 10'd256, 10'd5, 32'h1234_5678);
      start <= 1'b0;
      drain();

      // both axes at the far corner, OR mode; unmapped CSRs must not stick
      csr_write(REG_CENTER_X, 32'hFFFF_FFFF);
      csr_write(REG_CENTER_Y, 32'h0000_03FF);
      csr_write(REG_SHADE_COLOR, 32'hFFFF_FFFF);
      csr_write(REG_INTENSITY, 32'h0000_00C8);
      csr_write(REG_OR_MODE, 32'hFFFF_FFFF);
      for (int code = REG_UNUSED_LO; code <= REG_UNUSED_HI; code++)
         csr_write(3'(code), 32'hFFFF_FFFF);
      send_pixel(10'd1023, 10'd1023, 10'd1023, 32'h0000_0000);
      send_pixel(10'd1, 10'd1000, 10'd1010, 32'h1234_5678);
      send_pixel(10'd2, 10'd0, 10'd0, 32'hFFFF_0000);
      send_pixel(10'd4, 10'd1023, 10'd823, 32'h0F0F_0F0F);
      send_pixel(10'd6, 10'd1023, 10'd824, 32'hF0F0_F0F0);
      start <= 1'b0;
      drain();

      // no axis in use: distance root is one
      csr_write(REG_CENTER_X, 32'h0000_0000);
      csr_write(REG_CENTER_Y, 32'hFFFF_FC00);
      csr_write(REG_SHADE_COLOR, 32'hDEAD_BEEF);
      csr_write(REG_INTENSITY, 32'h0000_0001);
      csr_write(REG_OR_MODE, 32'h0000_0000);
      send_pixel(10'd7, 10'd1023, 10'd0, 32'hFFFF_FFFF);
      start <= 1'b0;
      drain();
      csr_write(REG_INTENSITY, 32'hFFFF_FF02);
      send_pixel(10'd8, 10'd0, 10'd1023, 32'h5555_5555);
      send_pixel(10'd9, 10'd1023, 10'd1023, 32'hAAAA_AAAA);
      start <= 1'b0;
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               cx    = '1;
               cy    = '1;
               color = '1;
               level = '1;
               mode  = 1'b1;
            end
            1: begin
               cx    = 10'd1;
               cy    = '0;
               color = 32'd1;
               level = '1;
               mode  = 1'b0;
            end
            default: begin
               cx    = pick_center();
               cy    = pick_center();
               color = ($urandom_range(0, 7) == 0) ? '1 : $urandom;
               level = ($urandom_range(0, 4) == 0) ? '1 : LEVEL_W'($urandom_range(0, 255));
               mode  = 1'($urandom_range(0, 1));
            end
         endcase
         csr_write(REG_CENTER_X, padded(CSR_W'(cx), COORD_W));
         csr_write(REG_CENTER_Y, padded(CSR_W'(cy), COORD_W));
         csr_write(REG_SHADE_COLOR, padded(color, COLOR_W));
         csr_write(REG_INTENSITY, padded(CSR_W'(level), LEVEL_W));
         csr_write(REG_OR_MODE, padded(CSR_W'(mode), 1));

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(0, 99) < 65) begin
               px = near_coord(cx);
               py = near_coord(cy);
            end else begin
               px = COORD_W'($urandom_range(0, 1023));
               py = COORD_W'($urandom_range(0, 1023));
            end
            send_pixel(INDEX_W'($urandom_range(0, 1023)), px, py, pick_old());
            gap = (p % 3 == 2) ? 0 : pick_gap();
            if (gap > 0 || i == ITEMS_PER_PHASE - 1)
               start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("radial_led_shader_test OK");
      else
         $display("radial_led_shader_test NOT OK");
      $finish;
   end

endmodule
